FILE: sv/sysex_7bit_unpacker_core_defines.svh
// ----------------------------------------------------------------------------
// SysEx unpacker assertion macros
// Shared concurrent assertion forms for the SysEx unpacker core.
// ----------------------------------------------------------------------------
`ifndef SYSEX_7BIT_UNPACKER_CORE_DEFINES_SVH
`define SYSEX_7BIT_UNPACKER_CORE_DEFINES_SVH

// same-cycle implication
`define SXU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sysex unpacker: assertion failed");

// next-cycle implication
`define SXU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sysex unpacker: assertion failed");

`endif

FILE: sv/sxu_pkg.sv
// ----------------------------------------------------------------------------
// SysEx unpacker package
// Types, codes and constants of the 7-bit to 8-bit SysEx unpacker.
// ----------------------------------------------------------------------------
package sxu_pkg;

  localparam int MAX_OUT = 2048;
  localparam int CNT_W   = 12;
  localparam int HDR_LEN = 5;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] SOX_BYTE  = 8'hF0;
  localparam logic [7:0] EOX_BYTE  = 8'hF7;
  localparam logic [6:0] LOW7_MASK = 7'h7F;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_message;
    status_e    status;
  } result_t;

  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      3'd0:    b = SOX_BYTE;
      3'd1:    b = 8'h00;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h61;
      3'd4:    b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/sxu_in_if.sv
// ----------------------------------------------------------------------------
// SysEx unpacker input channel
// Raw message bytes with an end-of-message mark.
// ----------------------------------------------------------------------------
interface sxu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

FILE: sv/sxu_out_if.sv
// ----------------------------------------------------------------------------
// SysEx unpacker result channel
// Decoded bytes with last mark and status.
// ----------------------------------------------------------------------------
interface sxu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_message;
  logic [1:0] status;

  modport source (output valid, output data_byte, output last_of_message,
                  output status, input ready);
  modport sink   (input valid, input data_byte, input last_of_message,
                  input status, output ready);
endinterface

FILE: sv/sxu_cfg_if.sv
// ----------------------------------------------------------------------------
// SysEx unpacker configuration channel
// Write channel for the suspended register.
// ----------------------------------------------------------------------------
interface sxu_cfg_if;
  logic valid;
  logic ready;
  logic suspended;

  modport source (output valid, output suspended, input ready);
  modport sink   (input valid, input suspended, output ready);
endinterface

FILE: sv/sysex_7bit_unpacker_core.sv
// ----------------------------------------------------------------------------
// SysEx 7-bit to 8-bit unpacker core
// Checks the F0 00 02 61 00 header and rebuilds 8-bit data from group bytes.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle while the input is ready and decoded
// in the same cycle into a four-entry result queue; results leave at one per
// cycle while the result side is ready. A message end can emit two results
// (the held byte and the final one), so the input is ready while the queue
// has room for two; with the result side always ready the core sustains one
// byte per cycle. Results are registered in the queue before they are offered.
// Bytes beyond 2048 decoded data bytes are dropped and the last result carries
// overflow status. The suspended register is sampled on each message's first byte.
module sysex_7bit_unpacker_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sxu_in_if.sink    sysex_i,
  sxu_out_if.source result_o,
  sxu_cfg_if.sink   cfg_i
);
  import sxu_pkg::*;
  `include "sysex_7bit_unpacker_core_defines.svh"

  logic             susp_q;
  logic [2:0]       hs_q, hs_d;
  logic             bad_q, bad_d;
  logic [2:0]       pos_q, pos_d;
  logic [6:0]       grp_q, grp_d;
  logic [2:0]       bidx_q, bidx_d;
  logic [7:0]       held_q, held_d;
  logic             hv_q, hv_d;
  logic [CNT_W-1:0] dcnt_q, dcnt_d;
  logic             ovf_q, ovf_d;

  result_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0]   head_q, tail_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  logic    in_fire, out_fire, eom;
  logic    res_a_v, res_b_v;
  result_t res_a, res_b, fin;
  logic [1:0] push_n;
  logic [7:0] grp_ext;
  logic [7:0] dec_byte;

  assign cfg_i.ready   = 1'b1;
  assign sysex_i.ready = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign in_fire       = sysex_i.valid & sysex_i.ready;
  assign out_fire      = result_o.valid & result_o.ready;
  assign eom           = sysex_i.end_of_message;
  assign grp_ext       = {1'b0, grp_q};
  assign dec_byte      = {grp_ext[bidx_q], sysex_i.in_byte[6:0] & LOW7_MASK};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      susp_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      susp_q <= cfg_i.suspended;
    end
  end

  always_comb begin
    hs_d    = hs_q;
    bad_d   = bad_q;
    pos_d   = pos_q;
    grp_d   = grp_q;
    bidx_d  = bidx_q;
    held_d  = held_q;
    hv_d    = hv_q;
    dcnt_d  = dcnt_q;
    ovf_d   = ovf_q;
    res_a_v = 1'b0;
    res_b_v = 1'b0;
    res_a   = '{data_byte: held_q, last_of_message: 1'b0, status: ST_OK};
    res_b   = res_a;
    fin     = res_a;

    if (in_fire) begin
      if (hs_q == 3'd0 && !bad_q && susp_q) begin
        bad_d = 1'b1;
      end
      if (!bad_d) begin
        if (hs_q < 3'(HDR_LEN)) begin
          if (sysex_i.in_byte == header_byte(hs_q)) begin
            hs_d = hs_q + 3'd1;
          end else begin
            bad_d = 1'b1;
          end
        end else if (!(eom && sysex_i.in_byte == EOX_BYTE)) begin
          if (pos_q == 3'd0) begin
            grp_d  = sysex_i.in_byte[6:0] & LOW7_MASK;
            pos_d  = 3'd1;
            bidx_d = 3'd0;
          end else begin
            bidx_d = bidx_q + 3'd1;
            pos_d  = pos_q + 3'd1;
            if (dcnt_q < CNT_W'(MAX_OUT)) begin
              if (hv_q) begin
                res_a_v = 1'b1;
              end
              held_d = dec_byte;
              hv_d   = 1'b1;
              dcnt_d = dcnt_q + CNT_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end

      if (eom) begin
        if (!bad_d && hs_d == 3'(HDR_LEN)) begin
          if (hv_d) begin
            fin = '{data_byte: held_d, last_of_message: 1'b1,
                    status: (ovf_d ? ST_OVERFLOW : ST_OK)};
          end else begin
            fin = '{data_byte: 8'h00, last_of_message: 1'b1, status: ST_EMPTY};
          end
          if (res_a_v) begin
            res_b   = fin;
            res_b_v = 1'b1;
          end else begin
            res_a   = fin;
            res_a_v = 1'b1;
          end
        end
        hs_d   = 3'd0;
        bad_d  = 1'b0;
        pos_d  = 3'd0;
        grp_d  = 7'd0;
        bidx_d = 3'd0;
        held_d = 8'h00;
        hv_d   = 1'b0;
        dcnt_d = '0;
        ovf_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q   <= 3'd0;
      bad_q  <= 1'b0;
      pos_q  <= 3'd0;
      grp_q  <= 7'd0;
      bidx_q <= 3'd0;
      held_q <= 8'h00;
      hv_q   <= 1'b0;
      dcnt_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      hs_q   <= hs_d;
      bad_q  <= bad_d;
      pos_q  <= pos_d;
      grp_q  <= grp_d;
      bidx_q <= bidx_d;
      held_q <= held_d;
      hv_q   <= hv_d;
      dcnt_q <= dcnt_d;
      ovf_q  <= ovf_d;
    end
  end

  assign push_n = {1'b0, res_a_v} + {1'b0, res_b_v};
  assign cnt_d  = cnt_q + QCNT_W'(push_n) - QCNT_W'(out_fire);

  always_ff @(posedge clk_i) begin
    if (res_a_v) begin
      q_mem[tail_q] <= res_a;
    end
    if (res_b_v) begin
      q_mem[tail_q + QPTR_W'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      tail_q <= tail_q + QPTR_W'(push_n);
      cnt_q  <= cnt_d;
      if (out_fire) begin
        head_q <= head_q + QPTR_W'(1);
      end
    end
  end

  assign result_o.valid           = (cnt_q != '0);
  assign result_o.data_byte       = q_mem[head_q].data_byte;
  assign result_o.last_of_message = q_mem[head_q].last_of_message;
  assign result_o.status          = q_mem[head_q].status;

  `SXU_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, 1'b1, cnt_q <= QCNT_W'(QDEPTH))
  `SXU_ASSERT_NOW(a_room_on_accept, clk_i, rst_ni, in_fire, cnt_q <= QCNT_W'(QDEPTH - 2))
  `SXU_ASSERT_NOW(a_held_needs_header, clk_i, rst_ni, hv_q, (hs_q == 3'(HDR_LEN)) && !bad_q)
  `SXU_ASSERT_NEXT(a_clear_at_end, clk_i, rst_ni, in_fire && eom, (hs_q == 3'd0) && !hv_q && (dcnt_q == '0) && !ovf_q)

endmodule

FILE: sim/sysex_7bit_unpacker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SysEx 7-bit to 8-bit unpacker core testbench
// Feeds headers, group and data bytes, broken, suspended and over-capacity
// messages. Every decoded result is checked against a behavioral predictor
// or a fixed value, under several handshake idle and stall patterns.
// ----------------------------------------------------------------------------
module sysex_7bit_unpacker_core_tb;
  import sxu_pkg::*;

  localparam real CLK_PERIOD    = 2.0;
  localparam int  STUCK_LIMIT   = 2000;
  localparam int  SETTLE_CYCLES = 4;
  localparam int  TAIL_CYCLES   = 8;
  localparam int  PHASE_BYTES   = 112;
  localparam int  FULL_BODY_LEN = (MAX_OUT / 7) * 8 +
                                  ((MAX_OUT % 7) != 0 ? (MAX_OUT % 7) + 1 : 0);

  localparam logic [7:0] HDR_SEQ [HDR_LEN] = '{SOX_BYTE, 8'h00, 8'h02, 8'h61, 8'h00};

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_TYPED
  } chk_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       eom;
    chk_e       chk;
    result_t    typed;
  } stim_row_t;

  localparam int DIR_N = 17;
  localparam stim_row_t DIR_TAB [DIR_N] = '{
    '{SOX_BYTE, 1'b0, CHK_NONE,  '{8'h00, 1'b0, ST_OK}},
    '{8'h00,    1'b0, CHK_NONE,  '{8'h00, 1'b0, ST_OK}},
    '{8'h02,    1'b0, CHK_NONE,  '{8'h00, 1'b0, ST_OK}},
    '{8'h61,    1'b0, CHK_NONE,  '{8'h00, 1'b0, ST_OK}},
    '{8'h00,    1'b1, CHK_TYPED, '{8'h00, 1'b1, ST_EMPTY}},
    '{SOX_BYTE, 1'b0, CHK_NONE,  '{8'h00, 1'b0, ST_OK}},
    '{8'h7F,    1'b1, CHK_NONE,  '{8'h00, 1'b0, ST_OK}},
    '{SOX_BYTE, 1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{8'h00,    1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{8'h02,    1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{8'h61,    1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{8'h00,    1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{8'hFF,    1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{8'hFF,    1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{8'h00,    1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{EOX_BYTE, 1'b0, CHK_MODEL, '{8'h00, 1'b0, ST_OK}},
    '{EOX_BYTE, 1'b1, CHK_MODEL, '{8'h00, 1'b0, ST_OK}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sxu_in_if  in_ch ();
  sxu_out_if res_ch ();
  sxu_cfg_if cfg_ch ();

  sysex_7bit_unpacker_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sysex_i  (in_ch),
    .result_o (res_ch),
    .cfg_i    (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state
  logic        susp_reg  = 1'b0;
  logic [2:0]  hdr_cnt   = '0;
  logic        hdr_bad   = 1'b0;
  logic [2:0]  body_pos  = '0;
  logic [6:0]  grp_bits  = '0;
  logic [2:0]  grp_idx   = '0;
  logic [7:0]  held_byte = '0;
  logic        held_ok   = 1'b0;
  logic [11:0] dec_cnt   = '0;
  logic        dropped   = 1'b0;

  result_t released [$];
  result_t pending_results [$];

  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int bytes_fed      = 0;
  int mismatch_count = 0;
  int stuck_cycles   = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic unpack_byte(input logic [7:0] b, input logic eom);
    logic [7:0] grp_ext;
    logic [7:0] value;
    result_t    r;
    released.delete();
    if (hdr_cnt == 3'd0 && !hdr_bad && susp_reg) hdr_bad = 1'b1;
    if (!hdr_bad) begin
      if (hdr_cnt < HDR_LEN) begin
        if (b == HDR_SEQ[hdr_cnt]) hdr_cnt = hdr_cnt + 3'd1;
        else hdr_bad = 1'b1;
      end else if (!(eom && b == EOX_BYTE)) begin
        if (body_pos == 3'd0) begin
          grp_bits = b[6:0];
          body_pos = 3'd1;
          grp_idx  = 3'd0;
        end else begin
          grp_ext  = {1'b0, grp_bits};
          value    = {grp_ext[grp_idx], b[6:0]};
          grp_idx  = grp_idx + 3'd1;
          body_pos = body_pos + 3'd1;
          if (dec_cnt < MAX_OUT) begin
            if (held_ok) begin
              r = '{held_byte, 1'b0, ST_OK};
              released.push_back(r);
            end
            held_byte = value;
            held_ok   = 1'b1;
            dec_cnt   = dec_cnt + 12'd1;
          end else begin
            dropped = 1'b1;
          end
        end
      end
    end
    if (eom) begin
      if (!hdr_bad && hdr_cnt == HDR_LEN) begin
        if (held_ok) r = '{held_byte, 1'b1, dropped ? ST_OVERFLOW : ST_OK};
        else r = '{8'h00, 1'b1, ST_EMPTY};
        released.push_back(r);
      end
      hdr_cnt   = '0;
      hdr_bad   = 1'b0;
      body_pos  = '0;
      grp_bits  = '0;
      grp_idx   = '0;
      held_byte = '0;
      held_ok   = 1'b0;
      dec_cnt   = '0;
      dropped   = 1'b0;
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_suspended(input logic value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.suspended <= value;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    susp_reg = value;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eom,
                           input chk_e chk = CHK_MODEL, input result_t typed = '0);
    if ($urandom_range(199) == 0) wait_drained();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.in_byte        <= b;
    in_ch.end_of_message <= eom;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    unpack_byte(b, eom);
    case (chk)
      CHK_MODEL: foreach (released[i]) pending_results.push_back(released[i]);
      CHK_TYPED: pending_results.push_back(typed);
      default: ;
    endcase
    bytes_fed++;
  endtask

  task automatic send_bytes(input logic [7:0] msg [$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_random_message();
    logic [7:0] msg [$];
    int kind;
    int body_len;
    int cut;
    kind = $urandom_range(99);
    if (kind < 75) begin
      foreach (HDR_SEQ[i]) msg.push_back(HDR_SEQ[i]);
      case ($urandom_range(3))
        0: body_len = $urandom_range(3);
        1: body_len = 8 * $urandom_range(3) + 1;
        default: body_len = $urandom_range(24);
      endcase
      repeat (body_len) msg.push_back(($urandom_range(19) == 0) ? EOX_BYTE : 8'($urandom));
      if ($urandom_range(1)) msg.push_back(EOX_BYTE);
    end else if (kind < 85) begin
      foreach (HDR_SEQ[i]) msg.push_back(HDR_SEQ[i]);
      cut = $urandom_range(HDR_LEN - 1);
      msg[cut] = msg[cut] ^ 8'($urandom_range(1, 255));
      repeat ($urandom_range(10)) msg.push_back(8'($urandom));
    end else if (kind < 93) begin
      cut = $urandom_range(1, HDR_LEN - 1);
      for (int i = 0; i < cut; i++) msg.push_back(HDR_SEQ[i]);
    end else begin
      repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
    end
    send_bytes(msg);
  endtask

  always @(posedge clk_i) res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.data_byte       = res_ch.data_byte;
      got.last_of_message = res_ch.last_of_message;
      got.status          = status_e'(res_ch.status);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unrequested result %02h last %0b status %0d",
                                  got.data_byte, got.last_of_message, got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.data_byte !== want.data_byte ||
            got.last_of_message !== want.last_of_message ||
            got.status !== want.status)
          report_mismatch($sformatf("result %02h/%0b/%0d, expected %02h/%0b/%0d",
                                    got.data_byte, got.last_of_message, got.status,
                                    want.data_byte, want.last_of_message, want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("sysex_7bit_unpacker_core_tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic [7:0] msg [$];
    int target;
    int saved_count;
    in_ch.valid          <= 1'b0;
    in_ch.in_byte        <= '0;
    in_ch.end_of_message <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.suspended     <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_suspended(1'b0);
    foreach (DIR_TAB[i])
      send_byte(DIR_TAB[i].in_byte, DIR_TAB[i].eom, DIR_TAB[i].chk, DIR_TAB[i].typed);
    write_suspended(1'b1);
    foreach (HDR_SEQ[i]) send_byte(HDR_SEQ[i], i == HDR_LEN - 1, CHK_NONE);
    write_suspended(1'b0);

    // fill to exactly capacity, then past it
    for (int k = 0; k < 2; k++) begin
      msg.delete();
      foreach (HDR_SEQ[i]) msg.push_back(HDR_SEQ[i]);
      repeat (FULL_BODY_LEN + (k == 0 ? 0 : $urandom_range(1, 40)))
        msg.push_back(8'($urandom_range(0, 127)));
      send_bytes(msg);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 71;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 71;
        end
        default: begin
          tx_idle_pct  = 6;
          rx_stall_pct = 6;
        end
      endcase
      if (phase == 2) begin
        saved_count = bytes_fed;
        write_suspended(1'b1);
        repeat (6) send_random_message();
        write_suspended(1'b0);
        bytes_fed = saved_count;
      end
      target = bytes_fed + PHASE_BYTES;
      while (bytes_fed < target) send_random_message();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sysex_7bit_unpacker_core_tb passed");
    end else begin
      $display("sysex_7bit_unpacker_core_tb failed");
    end
    $finish;
  end

endmodule
